// ----- rtl/core/lmsf_pkg.sv -----
// lmsf_pkg: shared constants, codes and command type for the led matrix scan frame store
// no dependencies; imported by lmsf_queue, lmsf_front, lmsf_back and the top level
package lmsf_pkg;

  // display geometry
  localparam int DISPLAY_WIDTH  = 96;
  localparam int DISPLAY_HEIGHT = 48;
  localparam int SCAN_PHASES    = 4;

  localparam int ROW_BYTES     = (DISPLAY_WIDTH + 7) / 8;
  localparam int ROW_BITS      = ROW_BYTES * 8;
  localparam int PANEL_BYTES   = 4;
  localparam int PANEL_ROWS    = 4 * SCAN_PHASES;
  localparam int PANELS_ACROSS = DISPLAY_WIDTH / (8 * PANEL_BYTES);
  localparam int PANELS_DOWN   = DISPLAY_HEIGHT / PANEL_ROWS;

  localparam int ROW_W   = $clog2(DISPLAY_HEIGHT);
  localparam int POS_W   = $clog2(ROW_BITS);
  localparam int BYTE_W  = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int PHASE_W = $clog2(SCAN_PHASES);
  localparam int KB_W    = $clog2(PANEL_BYTES);
  localparam int PD_W    = (PANELS_DOWN > 1) ? $clog2(PANELS_DOWN) : 1;
  localparam int PA_W    = (PANELS_ACROSS > 1) ? $clog2(PANELS_ACROSS) : 1;

  localparam int QUEUE_DEPTH = 2;

  // input actions
  localparam logic [2:0] ACT_SET   = 3'd0;
  localparam logic [2:0] ACT_CLR   = 3'd1;
  localparam logic [2:0] ACT_FILL  = 3'd2;
  localparam logic [2:0] ACT_CLEAR = 3'd3;
  localparam logic [2:0] ACT_SCAN  = 3'd4;

  // back end operations
  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_SCAN  = 2'd2;

  typedef logic [ROW_BITS-1:0]             row_t;
  typedef logic [ROW_BYTES-1:0][7:0]       row_bytes_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [ROW_W-1:0]  row_a;     // pixel row, or upper scan row
    logic [ROW_W-1:0]  row_b;     // lower scan row
    logic [POS_W-1:0]  pos;       // bit position within a row
    logic [BYTE_W-1:0] scan_col;  // byte of the row for a scan word
    logic              val;       // pixel or fill value
    logic [1:0]        scan_row;
    logic              latch;
  } cmd_t;

endpackage

// ----- rtl/core/lmsf_ram.sv -----
// lmsf_ram: generic single write port, single read port ram with registered read
// no dependencies
module lmsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/lmsf_queue.sv -----
// lmsf_queue: short command queue between front and back end
// depends on lmsf_pkg (cmd_t, QUEUE_DEPTH)
module lmsf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  lmsf_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output lmsf_pkg::cmd_t rd_data,
  output logic          empty
);
  import lmsf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/lmsf_front.sv -----
// lmsf_front: accepts input beats, maps pixels, tracks scan position, emits commands
// depends on lmsf_pkg (geometry, action and op codes, cmd_t)
module lmsf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [2:0]     action,
  input  logic [6:0]     pixel_x,
  input  logic [5:0]     pixel_y,
  input  logic           cfg_we,
  input  logic           cfg_data,
  input  logic           q_full,
  output logic           q_push,
  output lmsf_pkg::cmd_t q_data
);
  import lmsf_pkg::*;

  logic               mirrored_panel;
  logic               k0;
  logic [KB_W-1:0]    kb;
  logic [PD_W-1:0]    kd;
  logic [PA_W-1:0]    ka;
  logic [PHASE_W-1:0] phase;
  logic               accept;
  logic               last;
  logic               cmd_ok;
  cmd_t               cmd;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && cmd_ok;
  assign q_data = cmd;

  assign last = k0 && (kb == KB_W'(PANEL_BYTES - 1)) && (kd == PD_W'(PANELS_DOWN - 1))
                && (ka == PA_W'(PANELS_ACROSS - 1));

  always_comb begin
    int upper;
    int col;
    logic x_ok;
    logic y_ok;
    upper = (PANELS_DOWN - 1 - int'(kd)) * PANEL_ROWS + int'(k0) * (2 * SCAN_PHASES)
            + (SCAN_PHASES - 1 - int'(phase));
    col   = (PANELS_ACROSS - 1 - int'(ka)) * PANEL_BYTES + (PANEL_BYTES - 1 - int'(kb));
    x_ok  = int'(pixel_x) < DISPLAY_WIDTH;
    y_ok  = int'(pixel_y) < DISPLAY_HEIGHT;
    cmd    = '0;
    cmd_ok = 1'b0;
    case (action)
      ACT_SET, ACT_CLR: begin
        // out-of-range pixels are dropped here
        cmd_ok    = x_ok && y_ok;
        cmd.op    = OP_PIXEL;
        cmd.val   = (action == ACT_SET);
        cmd.row_a = mirrored_panel ? ROW_W'(DISPLAY_HEIGHT - 1 - int'(pixel_y))
                                   : ROW_W'(pixel_y);
        // mirrored byte and bit flip collapse to a reversed row position
        cmd.pos   = mirrored_panel ? POS_W'(ROW_BITS - 1 - int'(pixel_x))
                                   : POS_W'(pixel_x);
      end
      ACT_FILL, ACT_CLEAR: begin
        cmd_ok  = 1'b1;
        cmd.op  = OP_FILL;
        cmd.val = (action == ACT_FILL);
      end
      ACT_SCAN: begin
        cmd_ok       = 1'b1;
        cmd.op       = OP_SCAN;
        cmd.row_a    = ROW_W'(upper);
        cmd.row_b    = ROW_W'(upper + SCAN_PHASES);
        cmd.scan_col = BYTE_W'(col);
        cmd.scan_row = 2'(phase);
        cmd.latch    = last;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mirrored_panel <= 1'b1;
    end else if (cfg_we) begin
      mirrored_panel <= cfg_data;
    end
  end

  // word position as a mixed-radix counter: half, panel byte, panel down, panel across
  always_ff @(posedge clk) begin
    if (rst) begin
      k0    <= 1'b0;
      kb    <= '0;
      kd    <= '0;
      ka    <= '0;
      phase <= '0;
    end else if (accept && action == ACT_SCAN) begin
      k0 <= !k0;
      if (k0) begin
        if (kb == KB_W'(PANEL_BYTES - 1)) begin
          kb <= '0;
          if (kd == PD_W'(PANELS_DOWN - 1)) begin
            kd <= '0;
            ka <= (ka == PA_W'(PANELS_ACROSS - 1)) ? '0 : ka + 1'b1;
          end else begin
            kd <= kd + 1'b1;
          end
        end else begin
          kb <= kb + 1'b1;
        end
      end
      if (last) begin
        phase <= (phase == PHASE_W'(SCAN_PHASES - 1)) ? '0 : phase + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/lmsf_back.sv -----
// lmsf_back: executes commands against the row store and holds the result register
// depends on lmsf_pkg and lmsf_ram
module lmsf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  lmsf_pkg::cmd_t q_data,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [15:0]    shift_word,
  output logic [1:0]     scan_row,
  output logic           latch_now
);
  import lmsf_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PIXEL = 2'd1;
  localparam logic [1:0] ST_HI    = 2'd2;
  localparam logic [1:0] ST_LO    = 2'd3;

  logic [1:0]                state;
  logic [1:0]                state_next;
  cmd_t                      cur;
  logic [DISPLAY_HEIGHT-1:0] row_valid;
  logic                      bg;
  logic [7:0]                hi_byte;
  logic                      out_valid;
  logic                      out_load;

  logic             rd_en;
  logic [ROW_W-1:0] rd_addr;
  row_t             rd_data;
  logic             wr_en;
  row_t             wr_data;
  logic [ROW_W-1:0] rd_row;   // row whose data sits in rd_data
  row_t             row_eff;
  row_bytes_t       row_b;

  lmsf_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (DISPLAY_HEIGHT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur.row_a),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // rows never written since reset or the last fill read as the background value
  assign rd_row  = (state == ST_LO) ? cur.row_b : cur.row_a;
  assign row_eff = row_valid[rd_row] ? rd_data : {ROW_BITS{bg}};
  assign row_b   = row_bytes_t'(row_eff);
  assign empty   = !out_valid;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = q_data.row_a;
    wr_en      = 1'b0;
    wr_data    = row_eff;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_data.op)
            OP_PIXEL: begin
              rd_en      = 1'b1;
              state_next = ST_PIXEL;
            end
            OP_SCAN: begin
              rd_en      = 1'b1;
              state_next = ST_HI;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_PIXEL: begin
        wr_en            = 1'b1;
        wr_data[cur.pos] = cur.val;
        state_next       = ST_IDLE;
      end
      ST_HI: begin
        rd_en      = 1'b1;
        rd_addr    = cur.row_b;
        state_next = ST_LO;
      end
      ST_LO: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      bg        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && !q_empty && q_data.op == OP_FILL) begin
        row_valid <= '0;
        bg        <= q_data.val;
      end
      if (wr_en) begin
        row_valid[cur.row_a] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (state == ST_HI) begin
      hi_byte <= row_b[cur.scan_col];
    end
    if (out_load) begin
      shift_word <= {hi_byte, row_b[cur.scan_col]};
      scan_row   <= cur.scan_row;
      latch_now  <= cur.latch;
    end
  end

endmodule

// ----- rtl/core/led_matrix_scan_framebuffer.sv -----
// led_matrix_scan_framebuffer: top level of the led matrix row-scan frame store
// depends on lmsf_pkg, lmsf_front, lmsf_queue, lmsf_back (and lmsf_ram below it)

// Frame store for a 96x48 one-bit led matrix built from a 3x3 arrangement of
// 32x16 panels. Input beats carry an action plus pixel_x / pixel_y: set pixel,
// clear pixel, fill all, clear all, or scan tick; unknown actions and pixels
// outside the frame are dropped. cfg_data written with cfg_we selects mirrored
// mapping (reset 1): x, y and bit order flipped. Only a scan tick returns a
// beat: a 16-bit shift_word (upper row byte high, the row four below it low,
// shift out msb first), the scan_row being loaded, and latch_now on the last of
// the 72 words of a phase, after which the phase advances. Timing: the front end
// takes one beat per cycle until its 2-entry command queue fills. The back end
// owns the row ram (one 96-bit row per entry), takes one command at a time and
// sets the sustained rate: a pixel write is a row read, then a write back; a
// scan tick is two row reads, then the result register load, which waits while
// an unpopped word holds that register; fill and clear only drop the per-row
// valid bits and set a background value. The reset clear works the same way, so
// there is no clearing pass and beats are taken straight after reset. A finished
// word waits in the result register while the front end keeps accepting beats
// until the command queue fills.
module led_matrix_scan_framebuffer (
  input  logic        clk,
  input  logic        rst,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [2:0]  action,
  input  logic [6:0]  pixel_x,
  input  logic [5:0]  pixel_y,
  // configuration: mirrored panel bit
  input  logic        cfg_we,
  input  logic        cfg_data,
  // result register side
  output logic        empty,
  input  logic        pop,
  output logic [15:0] shift_word,
  output logic [1:0]  scan_row,
  output logic        latch_now
);
  import lmsf_pkg::*;

  // command path between front and back end
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_wr;
  cmd_t q_rd;

  // front end: decode, pixel mapping, scan position counters, config register
  lmsf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .action   (action),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr)
  );

  // decoupling queue so either side can stall alone
  lmsf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  // back end: row ram, valid bits, read-modify-write and scan word assembly
  lmsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_rd),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .shift_word (shift_word),
    .scan_row   (scan_row),
    .latch_now  (latch_now)
  );

  // front end never pushes into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // back end never takes a command from an empty queue
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  // reset leaves no result pending and the input side open
  a_reset_idle: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("block not idle after reset");

endmodule
